[design/bptc_pkg.sv]
// ----------------------------------------------------------------------------
// bptc_pkg
// Types, widths and constants shared by the pressure/temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // Field widths
  localparam int RawW    = 24;  // raw ADC conversion
  localparam int CoefW   = 16;  // calibration word
  localparam int OutW    = 32;  // result fields
  localparam int CfgIdxW = 3;   // configuration register index

  // Internal widths (ranges follow from 24-bit raws and 16-bit words)
  localparam int DtW    = 25;   // raw temperature minus reference
  localparam int MulW   = 42;   // coefficient times dT
  localparam int DtSqW  = 50;   // dT squared
  localparam int AccW   = 42;   // offset and sensitivity
  localparam int TempW  = 20;   // temperature in 0.01 degC
  localparam int T2W    = 18;   // second-order temperature term
  localparam int SqW    = 36;   // square of distance to a threshold
  localparam int PLoW   = 21;   // low slice of sensitivity for the split multiply
  localparam int ProdW  = 64;   // raw pressure times sensitivity
  localparam int DiffW  = 44;   // scaled product minus offset

  // Register stages from request to result
  localparam int PipeDepth = 9;

  // Temperature thresholds in 0.01 degC
  localparam logic signed [TempW-1:0] TempRef  = 20'sd2000;
  localparam logic signed [TempW-1:0] TempCold = -20'sd1500;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSens     = 3'd0,
    CfgOffset   = 3'd1,
    CfgSensTc   = 3'd2,
    CfgOffsetTc = 3'd3,
    CfgRefTemp  = 3'd4,
    CfgTempTc   = 3'd5
  } cfg_idx_e;

  // Calibration words
  typedef struct packed {
    logic [CoefW-1:0] sens;
    logic [CoefW-1:0] offset;
    logic [CoefW-1:0] sens_tc;
    logic [CoefW-1:0] offset_tc;
    logic [CoefW-1:0] ref_temp;
    logic [CoefW-1:0] temp_tc;
  } cal_t;

  // Raw conversion pair
  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } meas_t;

  // First-order values
  typedef struct packed {
    logic [RawW-1:0]        d1;
    logic signed [AccW-1:0] off;
    logic signed [AccW-1:0] sens;
    logic signed [TempW-1:0] temp;
    logic [T2W-1:0]         t2;
  } first_t;

  // Corrected values
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [AccW-1:0]  off;
    logic signed [AccW-1:0]  sens;
    logic signed [TempW-1:0] temp;
  } corr_t;

  // Result pair
  typedef struct packed {
    logic signed [OutW-1:0] pressure;
    logic signed [OutW-1:0] temperature;
  } result_t;

endpackage

[design/bptc_meas_if.sv]
// ----------------------------------------------------------------------------
// bptc_meas_if
// Request channel carrying one raw pressure/temperature conversion pair.
// ----------------------------------------------------------------------------
interface bptc_meas_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

[design/bptc_res_if.sv]
// ----------------------------------------------------------------------------
// bptc_res_if
// Result channel carrying compensated pressure and temperature.
// ----------------------------------------------------------------------------
interface bptc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure;
  logic signed [31:0] temperature;

  modport source (output valid, output pressure, output temperature, input ready);
  modport sink   (input valid, input pressure, input temperature, output ready);
endinterface

[design/bptc_cfg_if.sv]
// ----------------------------------------------------------------------------
// bptc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/bptc_first.sv]
// ----------------------------------------------------------------------------
// bptc_first
// Three-stage segment: dT, coefficient products, first-order offset,
// sensitivity and temperature.
// ----------------------------------------------------------------------------
module bptc_first (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bptc_pkg::cal_t      cal_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  bptc_pkg::meas_t     data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bptc_pkg::first_t    data_o
);
  import bptc_pkg::*;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  // stage 1
  logic [RawW-1:0]        s1_d1_q;
  logic signed [DtW-1:0]  s1_dt_q;
  logic signed [DtW-1:0]  dt_d;
  // stage 2
  logic [RawW-1:0]        s2_d1_q;
  logic signed [MulW-1:0] s2_off_p_q, s2_sens_p_q, s2_temp_p_q;
  logic signed [DtSqW-1:0] s2_dtsq_q;
  logic signed [MulW-1:0] off_p_d, sens_p_d, temp_p_d;
  logic signed [DtSqW-1:0] dtsq_d;
  // stage 3
  first_t                 s3_q;
  first_t                 s3_d;
  logic signed [MulW-1:0] temp_sh;

  // per-stage ready: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[2] = !vld_q[2] || ready_i;
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[2];
  assign data_o  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  // dT = D2 - C5 * 256
  assign dt_d = $signed({1'b0, data_i.raw_temperature})
              - $signed({1'b0, cal_i.ref_temp, 8'h00});

  // coefficient products and dT squared
  always_comb begin
    off_p_d  = $signed({1'b0, cal_i.offset_tc}) * s1_dt_q;
    sens_p_d = $signed({1'b0, cal_i.sens_tc}) * s1_dt_q;
    temp_p_d = $signed({1'b0, cal_i.temp_tc}) * s1_dt_q;
    dtsq_d   = s1_dt_q * s1_dt_q;
  end

  // first-order values; t2 is formed here and gated later
  always_comb begin
    temp_sh   = s2_temp_p_q >>> 23;
    s3_d.d1   = s2_d1_q;
    s3_d.off  = $signed({9'b0, cal_i.offset, 17'b0}) + (s2_off_p_q >>> 6);
    s3_d.sens = $signed({10'b0, cal_i.sens, 16'b0}) + (s2_sens_p_q >>> 7);
    s3_d.temp = $signed(temp_sh[TempW-1:0]) + TempRef;
    s3_d.t2   = s2_dtsq_q[31+T2W-1:31];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      s1_d1_q <= data_i.raw_pressure;
      s1_dt_q <= dt_d;
    end
    if (rdy[1] && vld_q[0]) begin
      s2_d1_q     <= s1_d1_q;
      s2_off_p_q  <= off_p_d;
      s2_sens_p_q <= sens_p_d;
      s2_temp_p_q <= temp_p_d;
      s2_dtsq_q   <= dtsq_d;
    end
    if (rdy[2] && vld_q[1]) begin
      s3_q <= s3_d;
    end
  end

endmodule

[design/bptc_corr.sv]
// ----------------------------------------------------------------------------
// bptc_corr
// Three-stage segment: low- and very-low-temperature tests, squares of the
// distance to each threshold, second-order corrections.
// ----------------------------------------------------------------------------
module bptc_corr (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  bptc_pkg::first_t    data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bptc_pkg::corr_t     data_o
);
  import bptc_pkg::*;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  // stage 4
  corr_t                   s4_base_q;
  logic                    s4_low_q, s4_cold_q;
  logic signed [TempW-1:0] s4_dw_q, s4_dc_q;
  logic [T2W-1:0]          s4_t2_q;
  // stage 5
  corr_t                   s5_base_q;
  logic [SqW-1:0]          s5_sqw_q, s5_sqc_q;
  logic signed [2*TempW-1:0] sqw_full, sqc_full;
  // stage 6
  corr_t                   s6_q;
  corr_t                   s6_d;
  logic [AccW-1:0]         off_w, off_c;

  always_comb begin
    rdy[2] = !vld_q[2] || ready_i;
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[2];
  assign data_o  = s6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  // squares, zeroed when the matching threshold is not crossed
  always_comb begin
    sqw_full = s4_dw_q * s4_dw_q;
    sqc_full = s4_dc_q * s4_dc_q;
  end

  // off -= 61*sqw/16 + 15*sqc, sens -= 2*sqw + 8*sqc
  always_comb begin
    off_w     = (({6'b0, s5_sqw_q} << 6) - ({6'b0, s5_sqw_q} << 1)
              - {6'b0, s5_sqw_q}) >> 4;
    off_c     = {2'b0, s5_sqc_q, 4'b0} - {6'b0, s5_sqc_q};
    s6_d.d1   = s5_base_q.d1;
    s6_d.temp = s5_base_q.temp;
    s6_d.off  = s5_base_q.off - $signed(off_w) - $signed(off_c);
    s6_d.sens = s5_base_q.sens - $signed({5'b0, s5_sqw_q, 1'b0})
              - $signed({3'b0, s5_sqc_q, 3'b0});
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      s4_base_q.d1   <= data_i.d1;
      s4_base_q.off  <= data_i.off;
      s4_base_q.sens <= data_i.sens;
      s4_base_q.temp <= data_i.temp;
      s4_low_q       <= data_i.temp < TempRef;
      s4_cold_q      <= data_i.temp < TempCold;
      s4_dw_q        <= data_i.temp - TempRef;
      s4_dc_q        <= data_i.temp - TempCold;
      s4_t2_q        <= (data_i.temp < TempRef) ? data_i.t2 : '0;
    end
    if (rdy[1] && vld_q[0]) begin
      s5_base_q.d1   <= s4_base_q.d1;
      s5_base_q.off  <= s4_base_q.off;
      s5_base_q.sens <= s4_base_q.sens;
      s5_base_q.temp <= s4_base_q.temp - $signed({2'b00, s4_t2_q});
      s5_sqw_q       <= s4_low_q  ? sqw_full[SqW-1:0] : '0;
      s5_sqc_q       <= s4_cold_q ? sqc_full[SqW-1:0] : '0;
    end
    if (rdy[2] && vld_q[1]) begin
      s6_q <= s6_d;
    end
  end

endmodule

[design/bptc_press.sv]
// ----------------------------------------------------------------------------
// bptc_press
// Three-stage segment: raw pressure times sensitivity as two partial
// products, their sum, then scaling and offset; last stage is the output.
// ----------------------------------------------------------------------------
module bptc_press (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  bptc_pkg::corr_t     data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bptc_pkg::result_t   data_o
);
  import bptc_pkg::*;

  localparam int PHiW = AccW - PLoW;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  // stage 7
  logic [RawW+PLoW-1:0]          s7_pl_q;
  logic signed [RawW+PHiW:0]     s7_ph_q;
  logic signed [AccW-1:0]        s7_off_q;
  logic signed [TempW-1:0]       s7_temp_q;
  logic [RawW+PLoW-1:0]          pl_d;
  logic signed [RawW+PHiW:0]     ph_d;
  // stage 8
  logic signed [ProdW-1:0]       s8_prod_q;
  logic signed [AccW-1:0]        s8_off_q;
  logic signed [TempW-1:0]       s8_temp_q;
  logic signed [ProdW-1:0]       prod_d;
  // stage 9 (output)
  result_t                       s9_q;
  result_t                       s9_d;
  logic signed [DiffW-1:0]       diff;

  always_comb begin
    rdy[2] = !vld_q[2] || ready_i;
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[2];
  assign data_o  = s9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  // partial products: unsigned low slice, signed high slice
  always_comb begin
    pl_d = data_i.d1 * data_i.sens[PLoW-1:0];
    ph_d = $signed({1'b0, data_i.d1}) * $signed(data_i.sens[AccW-1:PLoW]);
  end

  // recombine; the high product stays within 43 bits
  assign prod_d = $signed({s7_ph_q[ProdW-PLoW-1:0], {PLoW{1'b0}}})
                + $signed({{(ProdW-RawW-PLoW){1'b0}}, s7_pl_q});

  // P = ((D1 * SENS >> 21) - OFF) >> 15
  always_comb begin
    diff             = $signed(s8_prod_q[ProdW-1:21]) - s8_off_q;
    s9_d.pressure    = $signed({{(OutW-DiffW+15){diff[DiffW-1]}}, diff[DiffW-1:15]});
    s9_d.temperature = $signed({{(OutW-TempW){s8_temp_q[TempW-1]}}, s8_temp_q});
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      s7_pl_q   <= pl_d;
      s7_ph_q   <= ph_d;
      s7_off_q  <= data_i.off;
      s7_temp_q <= data_i.temp;
    end
    if (rdy[1] && vld_q[0]) begin
      s8_prod_q <= prod_d;
      s8_off_q  <= s7_off_q;
      s8_temp_q <= s7_temp_q;
    end
    if (rdy[2] && vld_q[1]) begin
      s9_q <= s9_d;
    end
  end

endmodule

[design/baro_pressure_temperature_compensation_core.sv]
// ----------------------------------------------------------------------------
// baro_pressure_temperature_compensation_core
// Turns raw pressure/temperature conversion pairs into compensated pressure
// (Pa) and temperature (0.01 degC) with second-order low-temperature terms.
// ----------------------------------------------------------------------------
// Usage:
//   meas_i  : one request per raw pair (raw_pressure, raw_temperature).
//   res_o   : one result per request, in order (pressure, temperature).
//   cfg_i   : writes the six calibration words, index 0..5 in the order
//             sens, offset, sens_tc, offset_tc, ref_temp, temp_tc; other
//             indexes are ignored. Always ready; write only while idle.
// Timing:
//   Nine register stages in three segments of three (first-order terms,
//   second-order corrections, pressure product). One request per cycle is
//   sustained while res_o is ready; the 64-bit pressure product is formed
//   as two partial products in stage 7 and summed in stage 8.
// Reset:
//   Clears all stage valid bits and sets every calibration word to zero.
// Back-pressure:
//   Each stage loads when it is empty or its successor moves, so bubbles
//   are squeezed out; with res_o stalled, meas_i stays ready until all
//   nine stages hold results.
// ----------------------------------------------------------------------------
module baro_pressure_temperature_compensation_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  bptc_meas_if.sink    meas_i,
  bptc_res_if.source   res_o,
  bptc_cfg_if.sink     cfg_i
);
  import bptc_pkg::*;

  localparam int OccW = $clog2(PipeDepth + 1);

  cal_t    cal_q;
  meas_t   meas;
  first_t  first_data;
  corr_t   corr_data;
  result_t res_data;
  logic    first_valid, first_ready;
  logic    corr_valid, corr_ready;
  logic    res_valid;
  logic    in_acc, out_acc;
  logic [OccW-1:0] occ_q, occ_d;

  // calibration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgSens:     cal_q.sens      <= cfg_i.data;
        CfgOffset:   cal_q.offset    <= cfg_i.data;
        CfgSensTc:   cal_q.sens_tc   <= cfg_i.data;
        CfgOffsetTc: cal_q.offset_tc <= cfg_i.data;
        CfgRefTemp:  cal_q.ref_temp  <= cfg_i.data;
        CfgTempTc:   cal_q.temp_tc   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign meas.raw_pressure    = meas_i.raw_pressure;
  assign meas.raw_temperature = meas_i.raw_temperature;

  // pipeline segments
  bptc_first u_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal_q),
    .valid_i (meas_i.valid),
    .ready_o (meas_i.ready),
    .data_i  (meas),
    .valid_o (first_valid),
    .ready_i (first_ready),
    .data_o  (first_data)
  );

  bptc_corr u_corr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (first_valid),
    .ready_o (first_ready),
    .data_i  (first_data),
    .valid_o (corr_valid),
    .ready_i (corr_ready),
    .data_o  (corr_data)
  );

  bptc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (corr_valid),
    .ready_o (corr_ready),
    .data_i  (corr_data),
    .valid_o (res_valid),
    .ready_i (res_o.ready),
    .data_o  (res_data)
  );

  assign res_o.valid       = res_valid;
  assign res_o.pressure    = res_data.pressure;
  assign res_o.temperature = res_data.temperature;

  // requests in flight
  assign in_acc  = meas_i.valid && meas_i.ready;
  assign out_acc = res_valid && res_o.ready;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) occ_d = occ_q + 1'b1;
    if (!in_acc && out_acc) occ_d = occ_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(PipeDepth))
    else $error("more requests in flight than pipeline stages");

  a_res_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> occ_q != '0)
    else $error("result without an outstanding request");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !meas_i.ready |-> (res_o.valid && !res_o.ready && occ_q == OccW'(PipeDepth)))
    else $error("request stalled while the pipeline has room");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.temperature[31:19] == {13{res_o.temperature[19]}}))
    else $error("temperature outside its 20-bit range");

endmodule
